// ===== src/rlsf_pkg.sv =====
package rlsf_pkg;

    // Axis count and derived address widths
    localparam int NUM_AXES  = 3;
    localparam int AXIS_W    = 2;
    localparam int ADDR_W    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int AX_EXT_W  = (ADDR_W > AXIS_W) ? ADDR_W : AXIS_W;
    localparam int AX_CMP_W  = AX_EXT_W + 1;

    // Field widths
    localparam int POS_W     = 16;
    localparam int VEL_W     = 17;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Stream payload layout, lowest bit first
    localparam int IN_TDATA_W   = 40;
    localparam int IN_AXIS_LSB  = 0;
    localparam int IN_TGT_LSB   = 2;
    localparam int IN_LIM_LSB   = 18;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_AXIS_LSB = 0;
    localparam int OUT_POS_LSB  = 2;
    localparam int OUT_VEL_LSB  = 18;
    localparam int OUT_STAT_LSB = 35;

    // Memory entry: velocity above position
    localparam int ENTRY_W = POS_W + VEL_W;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_SNAP  = 2'd0,
        ST_TRACK = 2'd1,
        ST_ACCEL = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_GAIN    = 3'd0,
        CFG_MIN_DISP      = 3'd1,
        CFG_MIN_VEL       = 3'd2,
        CFG_MAX_VEL_STEP  = 3'd3,
        CFG_MIN_VEL_STEP  = 3'd4,
        CFG_STEP_TIME     = 3'd5
    } cfg_idx_t;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_SPEED_GAIN   = 16'd2560;
    localparam logic [CFG_W-1:0] RST_MIN_DISP     = 16'd51;
    localparam logic [CFG_W-1:0] RST_MIN_VEL      = 16'd128;
    localparam logic [CFG_W-1:0] RST_MAX_VEL_STEP = 16'd1024;
    localparam logic [CFG_W-1:0] RST_MIN_VEL_STEP = 16'd3;
    localparam logic [CFG_W-1:0] RST_STEP_TIME    = 16'd1311;

endpackage

// ===== src/rate_limited_setpoint_follower_core.sv =====
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   axis[1:0], target[17:2], speed_limit[33:18], zero pad to 40
// m_axis    out  axis_out[1:0], position[17:2], velocity[34:18], status[36:35], pad
// cfg       in   cfg_we / cfg_addr / cfg_wdata, one register write per cycle
//
// Each input beat passes memory read, gain multiply, velocity limit,
// step-time multiply and write-back, in that order. The state memory and the two
// multiplies in series keep one beat in flight; a new beat is taken once write-back is done.
// Reset loads the configuration defaults and clears the FSM and the per-axis valid
// bits, so every axis reads as zero position and velocity until it is first written.
// A stalled m_axis holds the block in write-back; the input side waits meanwhile.
module rate_limited_setpoint_follower_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // axis[1:0], target[17:2], speed_limit[33:18]
    input  logic [rlsf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // axis_out[1:0], position[17:2], velocity[34:18], status[36:35]
    output logic [rlsf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_we,
    input  logic [rlsf_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [rlsf_pkg::CFG_W-1:0]          cfg_wdata
);
    import rlsf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_VEL  = 5'b00100,
        S_MUL2 = 5'b01000,
        S_WB   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [CFG_W-1:0] speed_gain_reg, min_disp_reg, min_vel_reg;
    logic [CFG_W-1:0] max_vel_step_reg, min_vel_step_reg, step_time_reg;

    // Input capture
    logic                    in_accept;
    logic [AXIS_W-1:0]       in_axis;
    logic [AX_EXT_W-1:0]     in_axis_ext;
    logic                    in_range;
    logic [AXIS_W-1:0]       axis_reg;
    logic                    in_range_reg;
    logic signed [POS_W-1:0] target_reg;
    logic [CFG_W-1:0]        limit_reg;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       addr_reg;

    // State memory and valid bits
    logic [ENTRY_W-1:0]      mem [NUM_AXES];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    rd_valid_reg;
    logic [NUM_AXES-1:0]     valid_reg;
    logic                    mem_we;
    logic [ENTRY_W-1:0]      wr_data;

    // Pipeline registers
    logic signed [POS_W-1:0] pos_old;
    logic signed [VEL_W-1:0] vel_old;
    logic signed [POS_W-1:0] pos_reg;
    logic signed [VEL_W-1:0] vold_reg;
    logic                    snap_reg;
    logic                    disp_neg_reg;
    logic [31:0]             prod1_reg;
    logic signed [VEL_W-1:0] vnew_reg;
    status_t                 status_reg;
    logic signed [17:0]      sum_reg;
    logic signed [34:0]      prod2_reg;

    // Stage logic
    logic signed [16:0]      disp;
    logic [16:0]             abs_disp_w;
    logic [15:0]             abs_disp;
    logic                    snap;
    logic [23:0]             mag_raw;
    logic [15:0]             mag;
    logic signed [17:0]      wanted;
    logic signed [17:0]      vold_ext;
    logic signed [17:0]      dv;
    logic [17:0]             abs_dv;
    logic signed [17:0]      max_step_s;
    logic signed [17:0]      vnew_w;
    status_t                 status_w;
    logic signed [34:0]      rounded;
    logic signed [17:0]      delta;
    logic signed [18:0]      pnew_wide;
    logic signed [POS_W-1:0] pnew;
    logic                    commit;

    // Output register
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic                    out_valid_reg, out_valid_next;

    assign s_axis_tready = state_reg[0];
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign in_axis       = s_axis_tdata[IN_AXIS_LSB +: AXIS_W];
    assign in_axis_ext   = AX_EXT_W'(in_axis);
    assign rd_addr       = in_axis_ext[ADDR_W-1:0];
    assign in_range      = (AX_CMP_W'(in_axis) < AX_CMP_W'(NUM_AXES));

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg   <= RST_SPEED_GAIN;
            min_disp_reg     <= RST_MIN_DISP;
            min_vel_reg      <= RST_MIN_VEL;
            max_vel_step_reg <= RST_MAX_VEL_STEP;
            min_vel_step_reg <= RST_MIN_VEL_STEP;
            step_time_reg    <= RST_STEP_TIME;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SPEED_GAIN:   speed_gain_reg   <= cfg_wdata;
                CFG_MIN_DISP:     min_disp_reg     <= cfg_wdata;
                CFG_MIN_VEL:      min_vel_reg      <= cfg_wdata;
                CFG_MAX_VEL_STEP: max_vel_step_reg <= cfg_wdata;
                CFG_MIN_VEL_STEP: min_vel_step_reg <= cfg_wdata;
                CFG_STEP_TIME:    step_time_reg    <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // State memory: read on accept, write on commit
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= wr_data;
        end
        if (in_accept && in_range)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: an unwritten axis reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (in_accept)
            begin
                rd_valid_reg <= in_range && valid_reg[rd_addr];
            end
        end
    end

    assign pos_old = rd_valid_reg ? $signed(rd_data_reg[POS_W-1:0]) : '0;
    assign vel_old = rd_valid_reg ? $signed(rd_data_reg[ENTRY_W-1:POS_W]) : '0;

    // Stage 1: displacement and gain product
    always_comb
    begin
        disp       = {target_reg[POS_W-1], target_reg} - {pos_old[POS_W-1], pos_old};
        abs_disp_w = disp[16] ? 17'(-disp) : 17'(disp);
        abs_disp   = abs_disp_w[15:0];
        snap       = abs_disp_w < {1'b0, min_disp_reg};
    end

    // Stage 2: wanted velocity, velocity step limit, velocity sum
    always_comb
    begin
        mag_raw = prod1_reg[31:8];
        if (mag_raw < 24'(min_vel_reg))
        begin
            mag = '0;
        end
        else if (mag_raw > 24'(limit_reg))
        begin
            mag = limit_reg;
        end
        else
        begin
            mag = mag_raw[15:0];
        end
        wanted     = disp_neg_reg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        vold_ext   = 18'(vold_reg);
        dv         = wanted - vold_ext;
        abs_dv     = dv[17] ? 18'(-dv) : 18'(dv);
        max_step_s = $signed({2'b00, max_vel_step_reg});
        status_w   = ST_TRACK;
        priority if (snap_reg)
        begin
            vnew_w   = '0;
            status_w = ST_SNAP;
        end
        else if (abs_dv < {2'b00, min_vel_step_reg})
        begin
            vnew_w = vold_ext;
        end
        else if (dv > max_step_s)
        begin
            vnew_w   = vold_ext + max_step_s;
            status_w = ST_ACCEL;
        end
        else if (dv < -max_step_s)
        begin
            vnew_w   = vold_ext - max_step_s;
            status_w = ST_ACCEL;
        end
        else
        begin
            vnew_w = wanted;
        end
    end

    // Stage 4: rounded position step and saturation
    always_comb
    begin
        rounded   = prod2_reg + 35'sd65536;
        delta     = rounded[34:17];
        pnew_wide = 19'(pos_reg) + 19'(delta);
        if (snap_reg)
        begin
            pnew = target_reg;
        end
        else if (pnew_wide > 19'sd32767)
        begin
            pnew = 16'sh7FFF;
        end
        else if (pnew_wide < -19'sd32768)
        begin
            pnew = 16'sh8000;
        end
        else
        begin
            pnew = pnew_wide[POS_W-1:0];
        end
    end

    assign commit  = state_reg[4] && (!out_valid_reg || m_axis_tready);
    assign mem_we  = commit && in_range_reg;
    assign wr_data = {vnew_reg, pnew};

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_accept) state_next = S_MUL1;
            S_MUL1: state_next = S_VEL;
            S_VEL:  state_next = S_MUL2;
            S_MUL2: state_next = S_WB;
            S_WB:   if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            axis_reg     <= in_axis;
            addr_reg     <= rd_addr;
            in_range_reg <= in_range;
            target_reg   <= $signed(s_axis_tdata[IN_TGT_LSB +: POS_W]);
            limit_reg    <= s_axis_tdata[IN_LIM_LSB +: CFG_W];
        end
        if (state_reg[1])
        begin
            pos_reg      <= pos_old;
            vold_reg     <= vel_old;
            snap_reg     <= snap;
            disp_neg_reg <= disp[16];
            prod1_reg    <= 32'(speed_gain_reg) * 32'(abs_disp);
        end
        if (state_reg[2])
        begin
            vnew_reg   <= vnew_w[VEL_W-1:0];
            status_reg <= status_w;
            sum_reg    <= vold_ext + vnew_w;
        end
        if (state_reg[3])
        begin
            prod2_reg <= 35'(sum_reg) * 35'($signed({1'b0, step_time_reg}));
        end
    end

    // Output beat register
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[OUT_AXIS_LSB +: AXIS_W] = axis_reg;
            if (in_range_reg)
            begin
                out_data_next[OUT_POS_LSB +: POS_W]   = pnew;
                out_data_next[OUT_VEL_LSB +: VEL_W]   = vnew_reg;
                out_data_next[OUT_STAT_LSB +: STAT_W] = status_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== src/rlsf_checker.sv =====
module rlsf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [rlsf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready
);
    import rlsf_pkg::*;

    logic [STAT_W-1:0] out_status;
    logic [VEL_W-1:0]  out_vel;

    assign out_status = m_axis_tdata[OUT_STAT_LSB +: STAT_W];
    assign out_vel    = m_axis_tdata[OUT_VEL_LSB +: VEL_W];

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // One beat in flight: input closes right after a beat is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a beat is in flight");

    // Snapped result carries zero velocity
    a_snap_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_status == ST_SNAP |-> out_vel == '0)
        else $error("snapped result with nonzero velocity");

    // Status takes a defined code only, velocity stays in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_status == ST_SNAP || out_status == ST_TRACK ||
                           out_status == ST_ACCEL) && out_vel != 17'h10000)
        else $error("result status or velocity out of range");

endmodule

bind rate_limited_setpoint_follower_core rlsf_checker u_rlsf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
